[design/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan package
// Shared sizes, register indices and types of the pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_PATTERN_LEN = 16;
    localparam int OFFSET_BITS     = 32;
    localparam int MATCH_W         = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int MASK_W          = 16;
    localparam int LENGTH_REG_W    = 5;

    // Width that holds a pattern length from 0 up to the maximum.
    localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
    // Width that addresses one window entry.
    localparam int IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_WILDCARD_MASK  = 2'd2,
        REG_PATTERN_LENGTH = 2'd3
    } cfg_index_t;

    typedef logic [MAX_PATTERN_LEN-1:0][7:0] byte_window_t;
    typedef logic [OFFSET_BITS-1:0]          offset_t;

endpackage

[design/wildcard_byte_pattern_scan.sv]
// A byte passes the input stage; its match is held in the output register.
// One byte per cycle unless stalled; the whole window is compared in one pass.
// Input stalls only when the input stage is full and the output beat waits.
// Reset clears window, byte count, pattern, mask, stage valids; length is 1.
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan
// Reports the buffer offset of every match of a wildcard byte pattern.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [7:0]                            data_byte,
    input  logic                                  first_of_buffer,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [wbps_pkg::MATCH_W-1:0]          match_start
);

    localparam int MaxLen = wbps_pkg::MAX_PATTERN_LEN;
    localparam int LenW   = wbps_pkg::LEN_W;
    localparam int IdxW   = wbps_pkg::IDX_W;
    localparam int OffW   = wbps_pkg::OFFSET_BITS;
    localparam int MatchW = wbps_pkg::MATCH_W;

    // Configuration registers
    logic [63:0]                        pattern_low_reg;
    logic [63:0]                        pattern_high_reg;
    logic [wbps_pkg::MASK_W-1:0]        wildcard_mask_reg;
    logic [wbps_pkg::LENGTH_REG_W-1:0]  pattern_length_reg;

    // Input stage
    logic                               s1_valid_reg;
    logic [7:0]                         s1_byte_reg;
    logic                               s1_first_reg;

    // Scan state
    wbps_pkg::byte_window_t             window_reg;
    wbps_pkg::byte_window_t             window_next;
    wbps_pkg::offset_t                  seen_reg;
    wbps_pkg::offset_t                  seen_next;

    // Output stage
    logic                               out_valid_reg;
    logic [MatchW-1:0]                  match_start_reg;
    logic [MatchW-1:0]                  match_start_next;

    logic                               advance;
    logic [LenW-1:0]                    len_eff;
    logic [127:0]                       pattern_all;
    logic [MaxLen-1:0]                  byte_ok;
    logic [LenW-1:0]                    cmp_idx [MaxLen];
    wbps_pkg::offset_t                  seen_base;
    logic                               hit;

    // The input stage moves on when the output register is free or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    assign out_valid   = out_valid_reg;
    assign match_start = match_start_reg;

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_eff = LenW'(1);
        end
        else if (32'(pattern_length_reg) > MaxLen)
        begin
            len_eff = LenW'(MaxLen);
        end
        else
        begin
            len_eff = LenW'(pattern_length_reg);
        end
    end

    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        // A new buffer starts from an empty window and a zero count.
        if (s1_first_reg)
        begin
            window_next = '0;
            seen_base   = '0;
        end
        else
        begin
            window_next = window_reg;
            seen_base   = seen_reg;
        end
        for (int k = MaxLen - 1; k > 0; k--)
        begin
            window_next[k] = window_next[k-1];
        end
        window_next[0] = s1_byte_reg;

        seen_next = (seen_base == '1) ? seen_base : seen_base + OffW'(1);

        // Pattern byte i lines up with window entry len-1-i.
        for (int i = 0; i < MaxLen; i++)
        begin
            cmp_idx[i] = len_eff - LenW'(i) - LenW'(1);
            byte_ok[i] = (LenW'(i) >= len_eff) || wildcard_mask_reg[i]
                         || (window_next[cmp_idx[i][IdxW-1:0]] == pattern_all[8*i +: 8]);
        end

        hit              = (&byte_ok) && (seen_next >= OffW'(len_eff));
        match_start_next = MatchW'(seen_next - OffW'(len_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= wbps_pkg::LENGTH_REG_W'(1);
        end
        else if (cfg_we)
        begin
            case (wbps_pkg::cfg_index_t'(cfg_index))
                wbps_pkg::REG_PATTERN_LOW:
                begin
                    pattern_low_reg <= cfg_data[63:0];
                end
                wbps_pkg::REG_PATTERN_HIGH:
                begin
                    pattern_high_reg <= cfg_data[63:0];
                end
                wbps_pkg::REG_WILDCARD_MASK:
                begin
                    wildcard_mask_reg <= cfg_data[wbps_pkg::MASK_W-1:0];
                end
                wbps_pkg::REG_PATTERN_LENGTH:
                begin
                    pattern_length_reg <= cfg_data[wbps_pkg::LENGTH_REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg  <= data_byte;
            s1_first_reg <= first_of_buffer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (s1_valid_reg)
            begin
                window_reg    <= window_next;
                seen_reg      <= seen_next;
                out_valid_reg <= hit;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && hit)
        begin
            match_start_reg <= match_start_next;
        end
    end

    // A waiting input beat is held in the input stage until it can move on.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_byte_reg)
                                      && $stable(s1_first_reg))
        else $error("input stage lost a waiting byte");

    // With nothing in the input stage, a taken result is not followed by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg && advance |=> !out_valid_reg)
        else $error("result produced without a byte");

    // The first byte of a buffer leaves a count of one.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg && s1_first_reg |=> seen_reg == OffW'(1))
        else $error("byte count not restarted by first byte of buffer");

    // Within a buffer the byte count never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg && !s1_first_reg |=> seen_reg >= $past(seen_reg))
        else $error("byte count decreased within a buffer");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan testbench
// Drives byte beats through the scanner under several register settings.
// A predictor in the bench keeps its own window and byte count. It queues
// the offset of every match, and each output beat is checked against the
// oldest queued offset. The run uses directed buffers first, then random
// buffers built mostly from copies of the pattern.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCAN_LATENCY   = 2;
    localparam int BYTES_PER_SET  = 60;
    localparam int RANDOM_SETS    = 9;
    localparam int DRAIN_GUARD    = 5000;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic [7:0] value;
        logic       first;
    } scan_beat_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [wbps_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [7:0]                           data_byte = 8'h00;
    logic                                 first_of_buffer = 1'b0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [wbps_pkg::MATCH_W-1:0]         match_start;

    // Bench copy of the registers and of the scanner state.
    logic [63:0]                          pattern_lo = '0;
    logic [63:0]                          pattern_hi = '0;
    logic [wbps_pkg::MASK_W-1:0]          wc_mask = '0;
    logic [wbps_pkg::LENGTH_REG_W-1:0]    length_reg = wbps_pkg::LENGTH_REG_W'(1);
    wbps_pkg::byte_window_t               window = '0;
    wbps_pkg::offset_t                    bytes_seen = '0;

    scan_beat_t                           pending_beats[$];
    logic [wbps_pkg::MATCH_W-1:0]         expected_starts[$];

    int                                   send_idle_pct = 0;
    int                                   recv_stall_pct = 0;
    int                                   beats_queued = 0;
    int                                   beats_accepted = 0;
    int                                   matches_checked = 0;
    int                                   settings_used = 1;
    int                                   error_count = 0;

    wildcard_byte_pattern_scan u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .first_of_buffer (first_of_buffer),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .match_start     (match_start)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int eff_len();
        int n;
        n = length_reg;
        if (n == 0)
            n = 1;
        if (n > wbps_pkg::MAX_PATTERN_LEN)
            n = wbps_pkg::MAX_PATTERN_LEN;
        return n;
    endfunction

    function automatic logic [7:0] pat_byte(input int i);
        logic [63:0] word;
        word = (i < 8) ? pattern_lo : pattern_hi;
        return word[(i % 8) * 8 +: 8];
    endfunction

    // Shift one byte into the window and queue a match offset if the last
    // pattern-length bytes agree with the pattern.
    task automatic predict_byte(input logic [7:0] b, input logic first);
        int                           n;
        bit                           hit;
        logic [wbps_pkg::MATCH_W-1:0] start;
        n = eff_len();
        if (first)
        begin
            window = '0;
            bytes_seen = '0;
        end
        for (int i = wbps_pkg::MAX_PATTERN_LEN - 1; i > 0; i--)
            window[i] = window[i - 1];
        window[0] = b;
        if (bytes_seen != '1)
            bytes_seen++;
        if (bytes_seen >= wbps_pkg::offset_t'(n))
        begin
            hit = 1'b1;
            for (int i = 0; i < n; i++)
                if (!wc_mask[i] && window[n - 1 - i] != pat_byte(i))
                    hit = 1'b0;
            if (hit)
            begin
                start = bytes_seen - wbps_pkg::offset_t'(n);
                expected_starts = {expected_starts, start};
            end
        end
    endtask

    // Driver: a new beat is loaded only once the previous one has gone.
    always @(posedge clk)
    begin
        scan_beat_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_byte(data_byte, first_of_buffer);
                beats_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_beats.pop_front();
                    in_valid        <= 1'b1;
                    data_byte       <= nxt.value;
                    first_of_buffer <= nxt.first;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted output beat against the oldest offset.
    always @(posedge clk)
    begin
        logic [wbps_pkg::MATCH_W-1:0] want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_starts.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected match_start %0d", match_start));
                end
                else
                begin
                    want = expected_starts.pop_front();
                    matches_checked++;
                    if (match_start !== want)
                        report_mismatch($sformatf("match_start %0d, expected %0d",
                                                  match_start, want));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic queue_beat(input logic [7:0] value, input logic first);
        scan_beat_t beat;
        beat.value = value;
        beat.first = first;
        pending_beats = {pending_beats, beat};
        beats_queued++;
    endtask

    task automatic write_reg(input wbps_pkg::cfg_index_t idx,
                             input logic [wbps_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            wbps_pkg::REG_PATTERN_LOW:    pattern_lo = value;
            wbps_pkg::REG_PATTERN_HIGH:   pattern_hi = value;
            wbps_pkg::REG_WILDCARD_MASK:  wc_mask = value[wbps_pkg::MASK_W-1:0];
            wbps_pkg::REG_PATTERN_LENGTH: length_reg = value[wbps_pkg::LENGTH_REG_W-1:0];
            default:                      ;
        endcase
    endtask

    task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [63:0] mask, input logic [63:0] len);
        write_reg(wbps_pkg::REG_PATTERN_LOW, lo);
        write_reg(wbps_pkg::REG_PATTERN_HIGH, hi);
        write_reg(wbps_pkg::REG_WILDCARD_MASK, mask);
        write_reg(wbps_pkg::REG_PATTERN_LENGTH, len);
        settings_used++;
    endtask

    // Waits until every queued beat has been taken and every match seen,
    // then lets the pipeline settle so that the next register write is safe.
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (beats_accepted != beats_queued)
            @(posedge clk);
        while (expected_starts.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_starts.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected match offsets never arrived",
                                      expected_starts.size()));
            expected_starts.delete();
        end
        repeat (SCAN_LATENCY + 6) @(posedge clk);
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0:
            begin
                send_idle_pct  = 25;
                recv_stall_pct = 76;
            end
            1:
            begin
                send_idle_pct  = 76;
                recv_stall_pct = 25;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic random_setup(input int set_no);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mask_word;
        logic [63:0] len_word;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if (set_no == 5)
        begin
            lo = '0;
            hi = '1;
        end
        mask_word = {$urandom, $urandom};
        case (set_no % 4)
            0:       mask_word[15:0] = 16'($urandom & $urandom & $urandom);
            1:       mask_word[15:0] = 16'h0000;
            2:       mask_word[15:0] = 16'($urandom);
            default: mask_word[15:0] = 16'hFFFF;
        endcase
        len_word = {$urandom, $urandom};
        case (set_no)
            0:       len_word[4:0] = 5'd16;
            1:       len_word[4:0] = 5'd1;
            2:       len_word[4:0] = 5'd31;
            3:       len_word[4:0] = 5'd0;
            4:       len_word[4:0] = 5'd17;
            default: len_word[4:0] = 5'($urandom_range(1, 16));
        endcase
        load_pattern(lo, hi, mask_word, len_word);
    endtask

    // Buffers are built from whole and broken copies of the pattern, plain
    // noise and runs of pattern bytes; a few are no longer than the pattern.
    task automatic queue_random_buffers(input int count);
        logic [7:0] buf_bytes[$];
        int         n;
        int         made;
        int         buf_len;
        int         seg;
        int         cut;
        n = eff_len();
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(9) == 0)
                buf_len = $urandom_range(1, n);
            else
                buf_len = $urandom_range(n, n + 40);
            buf_bytes.delete();
            while (buf_bytes.size() < buf_len)
            begin
                seg = $urandom_range(9);
                if (seg < 6)
                begin
                    cut = (seg < 4) ? n : $urandom_range(1, n);
                    for (int i = 0; i < cut; i++)
                        buf_bytes = {buf_bytes, (wc_mask[i] ? 8'($urandom) : pat_byte(i))};
                end
                else if (seg < 8)
                begin
                    repeat ($urandom_range(1, 4)) buf_bytes = {buf_bytes, 8'($urandom)};
                end
                else
                begin
                    repeat ($urandom_range(1, n))
                        buf_bytes = {buf_bytes, pat_byte($urandom_range(0, n - 1))};
                end
            end
            for (int i = 0; i < buf_len; i++)
                queue_beat(buf_bytes[i], i == 0);
            made += buf_len;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(0);

        // Reset settings: a single zero byte with no wildcard.
        queue_beat(8'h00, 1'b1);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'h7F, 1'b0);
        queue_beat(8'h00, 1'b0);
        wait_drained();

        // Wildcard in the second position; a buffer cut short by a new start
        // must not match across the restart.
        load_pattern(64'hFFEE_DDCC_4433_2211, 64'h0, 64'h2, 64'd4);
        queue_beat(8'h11, 1'b1);
        queue_beat(8'h99, 1'b0);
        queue_beat(8'h33, 1'b0);
        queue_beat(8'h11, 1'b1);
        queue_beat(8'h5A, 1'b0);
        queue_beat(8'h33, 1'b0);
        queue_beat(8'h44, 1'b0);
        wait_drained();

        // Overlapping matches; the length write carries junk in its upper bits.
        load_pattern(64'hAAAA, 64'h0123_4567_89AB_CDEF, 64'h0, 64'hFFFF_FFFF_FFFF_FFE2);
        queue_beat(8'hAA, 1'b1);
        queue_beat(8'hAA, 1'b0);
        queue_beat(8'hAA, 1'b0);
        queue_beat(8'hAA, 1'b0);
        wait_drained();

        // A length of zero behaves as one.
        load_pattern(64'h80, '1, 64'hFFFF_FFFF_FFFF_0000, 64'h20);
        queue_beat(8'h80, 1'b1);
        queue_beat(8'h01, 1'b0);
        queue_beat(8'h80, 1'b0);
        queue_beat(8'h80, 1'b1);
        wait_drained();

        for (int s = 0; s < RANDOM_SETS; s++)
        begin
            set_idling(s / 3);
            random_setup(s);
            queue_random_buffers(BYTES_PER_SET);
            wait_drained();
        end

        $display("Scanned %0d bytes under %0d register settings, checked %0d match offsets.",
                 beats_accepted, settings_used, matches_checked);
        $display("Pattern lengths 0 to 31, empty and full wildcard masks, short buffers.");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
design/wbps_pkg.sv
design/wildcard_byte_pattern_scan.sv
tb/sv/testbench.sv
